// ----- src/fpsc_pkg.sv -----
// Package for the camera pose block: op codes, CORDIC table, register indexes.
// No dependencies.
`default_nettype none
package fpsc_pkg;
	typedef enum logic [2:0] {
		OP_FORWARD = 3'd0,
		OP_STRAFE  = 3'd1,
		OP_YAW     = 3'd2,
		OP_PITCH   = 3'd3,
		OP_RELOAD  = 3'd4
	} op_t;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_PITCH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_YAW = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_SPEED = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_RATE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_RATE = 3'd7;

	localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] amount;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] right_x;
		logic signed [31:0] right_z;
		logic signed [31:0] up_x;
		logic signed [31:0] up_y;
		logic signed [31:0] up_z;
		logic signed [31:0] back_x;
		logic signed [31:0] back_y;
		logic signed [31:0] back_z;
		logic signed [31:0] shift_x;
		logic signed [31:0] shift_y;
		logic signed [31:0] shift_z;
	} view_t;

	// arctangent table in binary angle units
	function automatic logic [29:0] atan_bam(input logic [4:0] i);
		case (i)
			5'd0: atan_bam = 30'd536870912;
			5'd1: atan_bam = 30'd316933406;
			5'd2: atan_bam = 30'd167458907;
			5'd3: atan_bam = 30'd85004756;
			5'd4: atan_bam = 30'd42667331;
			5'd5: atan_bam = 30'd21354465;
			5'd6: atan_bam = 30'd10679838;
			5'd7: atan_bam = 30'd5340245;
			5'd8: atan_bam = 30'd2670163;
			5'd9: atan_bam = 30'd1335087;
			5'd10: atan_bam = 30'd667544;
			5'd11: atan_bam = 30'd333772;
			5'd12: atan_bam = 30'd166886;
			5'd13: atan_bam = 30'd83443;
			5'd14: atan_bam = 30'd41722;
			5'd15: atan_bam = 30'd20861;
			5'd16: atan_bam = 30'd10430;
			5'd17: atan_bam = 30'd5215;
			5'd18: atan_bam = 30'd2608;
			5'd19: atan_bam = 30'd1304;
			5'd20: atan_bam = 30'd652;
			5'd21: atan_bam = 30'd326;
			5'd22: atan_bam = 30'd163;
			5'd23: atan_bam = 30'd81;
			5'd24: atan_bam = 30'd41;
			5'd25: atan_bam = 30'd20;
			5'd26: atan_bam = 30'd10;
			5'd27: atan_bam = 30'd5;
			5'd28: atan_bam = 30'd3;
			5'd29: atan_bam = 30'd1;
			5'd30: atan_bam = 30'd1;
			default: atan_bam = 30'd0;
		endcase
	endfunction

	// clamp to [-2^30, 2^30]
	function automatic logic signed [31:0] sat30(input logic signed [65:0] v);
		if (v > 66'sd1073741824) sat30 = 32'sd1073741824;
		else if (v < -66'sd1073741824) sat30 = -32'sd1073741824;
		else sat30 = v[31:0];
	endfunction
endpackage
`default_nettype wire

// ----- src/fpsc_stream_if.sv -----
// Valid/ready channel carrying one payload type.
// Depends on nothing; payload type set by parameter.
`default_nettype none
interface fpsc_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/fpsc_cordic.sv -----
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
// Depends on fpsc_pkg.
`default_nettype none
module fpsc_cordic
	import fpsc_pkg::*;
#(
	parameter int STEPS = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [31:0]        angle,
	output logic                    done,
	output logic signed [31:0]      sin_q30,
	output logic signed [31:0]      cos_q30
);
	localparam int CW = $clog2(STEPS + 1);

	logic signed [33:0] x_q, y_q, z_q;
	logic               flip_q, busy_q;
	logic [CW-1:0]      i_q;
	logic [31:0]        fold;
	logic               flip;
	logic signed [33:0] xs, ys, at;

	assign flip = angle[31] ^ angle[30];
	assign fold = flip ? angle - 32'h8000_0000 : angle;
	assign xs = x_q >>> i_q[4:0];
	assign ys = y_q >>> i_q[4:0];
	assign at = $signed({4'd0, atan_bam(i_q[4:0])});

	// iterate one rotation per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
			flip_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
				flip_q <= flip;
				x_q <= GAIN_Q30;
				y_q <= '0;
				z_q <= {{2{fold[31]}}, fold};
			end else if (busy_q) begin
				if (i_q == CW'(STEPS)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end else begin
					if (!z_q[33]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + at;
					end
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	assign sin_q30 = sat30(66'(flip_q ? -y_q : y_q));
	assign cos_q30 = sat30(66'(flip_q ? -x_q : x_q));
endmodule
`default_nettype wire

// ----- src/fpsc_mul.sv -----
// Registered signed 34x34 multiply used by the sequencer.
// Depends on nothing else.
`default_nettype none
module fpsc_mul (
	input  wire logic               clk,
	input  wire logic signed [33:0] a,
	input  wire logic signed [33:0] b,
	output logic signed [67:0]      p_s1
);
	// register each product
	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end
endmodule
`default_nettype wire

// ----- src/fps_camera_pose_view_matrix_top.sv -----
// Top level of the camera pose block: sequencer, pose state, config registers.
// Depends on fpsc_pkg, fpsc_stream_if, fpsc_cordic, fpsc_mul.
//
//  channel | dir | payload                           | handshake
//  cmd     | in  | op[2:0], amount[31:0]             | valid/ready
//  view    | out | 8 rotation Q2.30, 3 shift Q16.16  | valid/ready
//  cfg     | in  | cfg_we, cfg_idx[2:0], cfg_data    | write enable
//
// One item at a time; each sin/cos pair runs the shared CORDIC for pitch, then for yaw.
// Forward/strafe: sin/cos before and after the move.
// Yaw/pitch: a divide by 360, then sin/cos; reload and unused codes: sin/cos only.
// Reset clears the pose and sets the registers to their defaults. A stalled result holds in
// the output register; the next item is processed meanwhile and waits in S_OUT for the slot.
`default_nettype none
module fps_camera_pose_view_matrix_top
	import fpsc_pkg::*;
#(
	parameter int CORDIC_STEPS = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	fpsc_stream_if.sink        cmd,
	fpsc_stream_if.source      view,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_idx,
	input  wire logic [31:0]   cfg_data
);
	typedef enum logic [3:0] {
		S_IDLE, S_SC1, S_SC2, S_D, S_MOVE, S_POSE, S_DIV, S_TRIG1, S_TRIG2,
		S_DOT, S_OUT
	} state_t;

	// floor(v/360) = (v * RECIP_360) >> 34 for v below 2^25
	localparam logic signed [33:0] RECIP_360 = 34'sd47721859;

	state_t state_q;
	logic [31:0] cfg_q [8];
	logic [31:0] eye_x_q, eye_y_q, eye_z_q, pitch_q, yaw_q;
	logic [2:0]  op_q;
	logic signed [31:0] amt_q;
	logic signed [31:0] sp_q, cp_q, sy_q, cy_q;
	logic signed [31:0] m_q [8];
	logic signed [31:0] d_q;
	logic [4:0]  k_q;
	logic signed [65:0] acc_q;
	logic [31:0] sh_x_q, sh_y_q, sh_z_q;
	logic        neg_q;
	logic [63:0] mag_q, quo_q;
	logic [8:0]  rem_q;
	view_t out_q;
	logic  out_v_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(REG_MOVE_SPEED); i++) cfg_q[i] <= '0;
			cfg_q[REG_MOVE_SPEED] <= 32'd65536;
			cfg_q[REG_PITCH_RATE] <= 32'd5719;
			cfg_q[REG_YAW_RATE] <= 32'd5719;
		end else if (cfg_we) begin
			cfg_q[cfg_idx] <= cfg_data;
		end
	end

	// shared CORDIC
	logic        sc_start, sc_done;
	logic [31:0] sc_angle;
	logic signed [31:0] sc_sin, sc_cos;
	fpsc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk, .arst_n, .start(sc_start), .angle(sc_angle), .done(sc_done),
		.sin_q30(sc_sin), .cos_q30(sc_cos)
	);

	// shared multiplier and operand select
	logic signed [33:0] ma, mb;
	logic signed [67:0] mp;
	fpsc_mul u_mul (.clk, .a(ma), .b(mb), .p_s1(mp));

	logic sc_phase_q;  // 0 pitch, 1 yaw
	logic sc_run_q;
	assign sc_angle = sc_phase_q ? yaw_q : pitch_q;

	// divide step: remainder joined with the next 16-bit digit of the magnitude
	logic [24:0] dv, qd_x360;
	logic [15:0] qd;
	assign dv = {rem_q, mag_q[63:48]};
	assign qd = mp[49:34];
	assign qd_x360 = 25'(qd) * 25'd360;

	// product index k: selects operand pair each state
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_D: begin
				ma = 34'(signed'(cfg_q[REG_MOVE_SPEED]));
				mb = 34'(amt_q);
			end
			S_MOVE: begin
				ma = (op_q == OP_FORWARD) ? -34'(d_q) : 34'(d_q);
				case (k_q[1:0])
					2'd0: mb = 34'(op_q == OP_FORWARD ? m_q[5] : m_q[0]);
					2'd1: mb = 34'(op_q == OP_FORWARD ? m_q[6] : 32'sd0);
					default: mb = 34'(op_q == OP_FORWARD ? m_q[7] : m_q[1]);
				endcase
			end
			S_POSE: begin
				ma = 34'(signed'(op_q == OP_YAW ? cfg_q[REG_YAW_RATE] : cfg_q[REG_PITCH_RATE]));
				mb = 34'(amt_q);
			end
			S_DIV: begin
				ma = 34'(dv);
				mb = RECIP_360;
			end
			S_TRIG1, S_TRIG2: begin
				case (k_q[1:0])
					2'd0: begin ma = 34'(sy_q); mb = 34'(sp_q); end
					2'd1: begin ma = 34'(cy_q); mb = 34'(sp_q); end
					2'd2: begin ma = 34'(sy_q); mb = 34'(cp_q); end
					default: begin ma = 34'(cp_q); mb = 34'(cy_q); end
				endcase
			end
			S_DOT: begin
				case (k_q[1:0])
					2'd0: ma = 34'(signed'(eye_x_q));
					2'd1: ma = 34'(signed'(eye_y_q));
					default: ma = 34'(signed'(eye_z_q));
				endcase
				case (k_q[3:2])
					2'd0: case (k_q[1:0])
						2'd0: mb = 34'(m_q[0]);
						2'd1: mb = '0;
						default: mb = 34'(m_q[1]);
					endcase
					2'd1: case (k_q[1:0])
						2'd0: mb = 34'(m_q[2]);
						2'd1: mb = 34'(m_q[3]);
						default: mb = 34'(m_q[4]);
					endcase
					default: case (k_q[1:0])
						2'd0: mb = 34'(m_q[5]);
						2'd1: mb = 34'(m_q[6]);
						default: mb = 34'(m_q[7]);
					endcase
				endcase
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// rounded helpers on the registered product
	logic signed [67:0] r30, r16;
	logic signed [31:0] q30s;
	logic [65:0] dot_sum;
	assign r30 = (mp + 68'sd536870912) >>> 30;
	assign r16 = (mp + 68'sd32768) >>> 16;
	assign q30s = sat30(r30[65:0]);
	assign dot_sum = acc_q + mp[65:0] + 66'sd536870912;

	// output slot is free or being emptied this cycle
	logic out_load;
	assign out_load = (state_q == S_OUT) && (!out_v_q || view.ready);
	assign cmd.ready = (state_q == S_IDLE);
	assign view.valid = out_v_q;
	assign view.data = out_q;
	assign sc_start = (state_q == S_SC1 || state_q == S_SC2) && !sc_run_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			eye_x_q <= '0; eye_y_q <= '0; eye_z_q <= '0;
			pitch_q <= '0; yaw_q <= '0;
			out_v_q <= 1'b0;
			sc_phase_q <= 1'b0;
			sc_run_q <= 1'b0;
			k_q <= '0;
		end else begin
			if (out_load) out_v_q <= 1'b1;
			else if (view.ready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: if (cmd.valid && cmd.ready) begin
					op_q <= cmd.data.op;
					amt_q <= cmd.data.amount;
					state_q <= (cmd.data.op == OP_FORWARD || cmd.data.op == OP_STRAFE)
						? S_SC1 : S_POSE;
					sc_phase_q <= 1'b0;
					k_q <= '0;
				end
				S_SC1, S_SC2: begin
					sc_run_q <= !sc_done;
					if (sc_done) begin
						if (!sc_phase_q) begin
							sp_q <= sc_sin; cp_q <= sc_cos;
							sc_phase_q <= 1'b1;
						end else begin
							sy_q <= sc_sin; cy_q <= sc_cos;
							sc_phase_q <= 1'b0;
							k_q <= '0;
							state_q <= (state_q == S_SC1) ? S_TRIG1 : S_TRIG2;
						end
					end
				end
				S_TRIG1, S_TRIG2: begin
					// products land in the cycle after issue
					if (k_q == 5'd0) begin
						m_q[0] <= cy_q; m_q[1] <= -sy_q;
						m_q[3] <= cp_q; m_q[6] <= -sp_q;
					end
					case (k_q)
						5'd1: m_q[2] <= q30s;
						5'd2: m_q[4] <= q30s;
						5'd3: m_q[5] <= q30s;
						5'd4: m_q[7] <= q30s;
						default: ;
					endcase
					if (k_q == 5'd4) begin
						k_q <= '0;
						state_q <= (state_q == S_TRIG1) ? S_D : S_DOT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_D: begin
					if (k_q == 5'd1) begin
						d_q <= r16[31:0];
						k_q <= '0;
						state_q <= S_MOVE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_MOVE: begin
					k_q <= k_q + 1'b1;
					case (k_q)
						5'd1: eye_x_q <= eye_x_q + r30[31:0];
						5'd2: if (op_q == OP_FORWARD) eye_y_q <= eye_y_q + r30[31:0];
						5'd3: eye_z_q <= eye_z_q + r30[31:0];
						default: ;
					endcase
					if (k_q == 5'd3) state_q <= S_SC2;
				end
				S_POSE: begin
					if (op_q == OP_RELOAD) begin
						eye_x_q <= cfg_q[REG_START_X];
						eye_y_q <= cfg_q[REG_START_Y];
						eye_z_q <= cfg_q[REG_START_Z];
						pitch_q <= cfg_q[REG_START_PITCH];
						yaw_q <= cfg_q[REG_START_YAW];
						state_q <= S_SC2;
					end else if (op_q != OP_YAW && op_q != OP_PITCH) begin
						state_q <= S_SC2;
					end else if (k_q == 5'd1) begin
						// split rate times amount into sign and magnitude for the divide
						neg_q <= mp[67];
						mag_q <= mp[67] ? 64'(-mp) : 64'(mp);
						quo_q <= '0;
						rem_q <= '0;
						k_q <= '0;
						state_q <= S_DIV;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DIV: begin
					// four 16-bit quotient digits, each issued and then taken from the registered product, then turn the angle
					if (k_q == 5'd8) begin
						if (op_q == OP_YAW)
							yaw_q <= neg_q ? yaw_q + quo_q[31:0] : yaw_q - quo_q[31:0];
						else
							pitch_q <= neg_q ? pitch_q + quo_q[31:0] : pitch_q - quo_q[31:0];
						k_q <= '0;
						state_q <= S_SC2;
					end else begin
						if (k_q[0]) begin
							quo_q <= {quo_q[47:0], qd};
							rem_q <= 9'(dv - qd_x360);
							mag_q <= {mag_q[47:0], 16'd0};
						end
						k_q <= k_q + 1'b1;
					end
				end
				S_DOT: begin
					// k[3:2] row, k[1:0] column; product lands next cycle
					k_q <= k_q + 1'b1;
					if (k_q[1:0] == 2'd3) begin
						acc_q <= '0;
						case (k_q[3:2])
							2'd0: sh_x_q <= 32'd0 - dot_sum[61:30];
							2'd1: sh_y_q <= 32'd0 - dot_sum[61:30];
							default: sh_z_q <= 32'd0 - dot_sum[61:30];
						endcase
						if (k_q[3:2] == 2'd2) state_q <= S_OUT;
					end else if (k_q[1:0] == 2'd0) begin
						acc_q <= '0;
					end else begin
						acc_q <= acc_q + mp[65:0];
					end
				end
				S_OUT: if (out_load) begin
					out_q.right_x <= m_q[0]; out_q.right_z <= m_q[1];
					out_q.up_x <= m_q[2]; out_q.up_y <= m_q[3]; out_q.up_z <= m_q[4];
					out_q.back_x <= m_q[5]; out_q.back_y <= m_q[6]; out_q.back_z <= m_q[7];
					out_q.shift_x <= sh_x_q;
					out_q.shift_y <= sh_y_q;
					out_q.shift_z <= sh_z_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a waiting result is held until it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !view.ready) |=> (out_v_q && $stable(out_q)))
		else $error("result overwritten");
	// no item taken while the sequencer is busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |-> (state_q == S_IDLE)) else $error("item taken while busy");
	// a CORDIC done only arrives while waiting for it
	assert property (@(posedge clk) disable iff (!arst_n)
		sc_done |-> (state_q == S_SC1 || state_q == S_SC2)) else $error("stray cordic done");
endmodule
`default_nettype wire
